// File: design/sorted_array_find_or_insert_unit_assert.svh
// assertion macros for the sorted array find-or-insert unit
// expects clk and rst_n in the scope of each use
`ifndef SORTED_ARRAY_FIND_OR_INSERT_UNIT_ASSERT_SVH
`define SORTED_ARRAY_FIND_OR_INSERT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SAFI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SAFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/safi_pkg.sv
// shared types and constants for the sorted array find-or-insert unit
// no dependencies
package safi_pkg;

  // default list depth
  localparam int DEPTH_DEF = 32;

  // field widths
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int KIND_W = 2;
  localparam int OP_W   = 2;

  // request op codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FOUND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

  // compare unit result
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// File: design/safi_mem.sv
// entry store: one write port, one registered read port
// depends on safi_pkg
module safi_mem #(
  parameter int DEPTH = safi_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [safi_pkg::VAL_W-1:0]   wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [safi_pkg::VAL_W-1:0]   rdata
);

  logic [safi_pkg::VAL_W-1:0] mem [DEPTH];
  logic [safi_pkg::VAL_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/safi_cmp.sv
// shared signed compare unit used by the scan
// depends on safi_pkg
module safi_cmp (
  input  logic signed [safi_pkg::VAL_W-1:0] entry,
  input  logic signed [safi_pkg::VAL_W-1:0] key,
  output safi_pkg::cmp_res_t                res
);

  // equal and greater-than of a stored entry against the key
  always_comb begin
    res.eq = (entry == key);
    res.gt = (entry > key);
  end

endmodule

// File: design/sorted_array_find_or_insert_unit.sv
// Clear, append and ignored ops answer with a single result; a query answers with a single
// result when the key is found or the list is full, else it inserts the key in order and
// then lists every entry of the array, one entry per result.
// Throughput: one request at a time; the serial scan and shift through the single read port
// of the entry store set how long each request takes.
// Reset (synchronous, active low) empties the list; the entry store is not cleared.
`include "sorted_array_find_or_insert_unit_assert.svh"
module sorted_array_find_or_insert_unit #(
  parameter int DEPTH = safi_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] position, [37:6] element, [39:38] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VAL_W = safi_pkg::VAL_W;
  localparam int POS_W = safi_pkg::POS_W;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CMP = 9'b000000100,
    S_SHF_RD   = 9'b000001000,
    S_SHF_WR   = 9'b000010000,
    S_INS      = 9'b000100000,
    S_LIST_RD  = 9'b001000000,
    S_LIST_OUT = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [CW-1:0]                       idx_r, idx_nxt;
  logic [CW-1:0]                       stop_r, stop_nxt;
  logic [VAL_W-1:0]                    value_r, value_nxt;
  logic [safi_pkg::KIND_W-1:0]         resp_kind_r, resp_kind_nxt;
  logic [POS_W-1:0]                    resp_pos_r, resp_pos_nxt;

  logic                                out_vld_r, out_vld_nxt;
  logic [safi_pkg::KIND_W-1:0]         out_kind_r, out_kind_nxt;
  logic [POS_W-1:0]                    out_pos_r, out_pos_nxt;
  logic [VAL_W-1:0]                    out_elem_r, out_elem_nxt;
  logic                                out_last_r, out_last_nxt;

  logic                                mem_we, mem_re;
  logic [AW-1:0]                       mem_waddr, mem_raddr;
  logic [VAL_W-1:0]                    mem_wdata, mem_rdata;
  safi_pkg::cmp_res_t                  cmp_res;

  logic                                full;
  logic                                out_free;
  logic                                in_fire;
  logic                                query_fire;
  logic [CW-1:0]                       count_inc;
  logic [CW-1:0]                       idx_inc, idx_dec;
  logic [POS_W+CW-1:0]                 pos_wide;
  logic [POS_W-1:0]                    pos_idx;

  // entry store and shared comparator
  safi_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  safi_cmp u_cmp (
    .entry (mem_rdata),
    .key   (value_r),
    .res   (cmp_res)
  );

  // helpers
  assign full       = (count_r == CW'(DEPTH));
  assign out_free   = !out_vld_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign query_fire = in_fire && (in_tuser == safi_pkg::OP_QUERY);
  assign count_inc  = CW'(count_r + 1'b1);
  assign idx_inc    = CW'(idx_r + 1'b1);
  assign idx_dec    = CW'(idx_r - 1'b1);
  assign pos_wide   = {{POS_W{1'b0}}, idx_r} + 1'b1;
  assign pos_idx    = pos_wide[POS_W-1:0];

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    stop_nxt      = stop_r;
    value_nxt     = value_r;
    resp_kind_nxt = resp_kind_r;
    resp_pos_nxt  = resp_pos_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_pos_nxt   = out_pos_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          value_nxt     = in_tdata;
          resp_kind_nxt = safi_pkg::KIND_ACK;
          resp_pos_nxt  = '0;
          state_nxt     = S_RESP;
          case (in_tuser)
            safi_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            safi_pkg::OP_APPEND: begin
              if (full) begin
                resp_kind_nxt = safi_pkg::KIND_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_tdata;
                count_nxt = count_inc;
              end
            end
            safi_pkg::OP_QUERY: begin
              idx_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
            default: begin
              // unused op, acknowledge only
            end
          endcase
        end
      end

      // issue the read of the next entry, or end of list
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          stop_nxt = count_r;
          if (full) begin
            resp_kind_nxt = safi_pkg::KIND_FULL;
            resp_pos_nxt  = '0;
            state_nxt     = S_RESP;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_INS;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_SCAN_CMP;
        end
      end

      // compare the entry against the key
      S_SCAN_CMP: begin
        if (cmp_res.eq) begin
          resp_kind_nxt = safi_pkg::KIND_FOUND;
          resp_pos_nxt  = pos_idx;
          state_nxt     = S_RESP;
        end else if (cmp_res.gt) begin
          stop_nxt = idx_r;
          if (full) begin
            resp_kind_nxt = safi_pkg::KIND_FULL;
            resp_pos_nxt  = '0;
            state_nxt     = S_RESP;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_SHF_RD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end

      // shift up: read entry below the hole
      S_SHF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_dec[AW-1:0];
        state_nxt = S_SHF_WR;
      end

      // shift up: move it into the hole
      S_SHF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec == stop_r) ? S_INS : S_SHF_RD;
      end

      // place the key at the stop point
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = stop_r[AW-1:0];
        mem_wdata = value_r;
        count_nxt = count_inc;
        idx_nxt   = '0;
        state_nxt = S_LIST_RD;
      end

      // list the whole array
      S_LIST_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = safi_pkg::KIND_LIST;
          out_pos_nxt  = pos_idx;
          out_elem_nxt = mem_rdata;
          out_last_nxt = (idx_inc == count_r);
          idx_nxt      = idx_inc;
          state_nxt    = (idx_inc == count_r) ? S_IDLE : S_LIST_RD;
        end
      end

      // single-result answer
      S_RESP: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = resp_kind_r;
          out_pos_nxt  = resp_pos_r;
          out_elem_nxt = '0;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    stop_r      <= stop_nxt;
    value_r     <= value_nxt;
    resp_kind_r <= resp_kind_nxt;
    resp_pos_r  <= resp_pos_nxt;
    out_kind_r  <= out_kind_nxt;
    out_pos_r   <= out_pos_nxt;
    out_elem_r  <= out_elem_nxt;
    out_last_r  <= out_last_nxt;
  end

  // result port
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_elem_r, out_pos_r};

  // checks
  `SAFI_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count beyond depth")
  `SAFI_ASSERT_NEXT(a_query_scan, query_fire, state_r == S_SCAN_RD, "query did not start scan")
  `SAFI_ASSERT_NEXT(a_ins_count, state_r == S_INS, count_r == $past(count_inc), "count not grown")
  `SAFI_ASSERT_IMPL(a_shift_above_stop, state_r == S_SHF_RD, idx_r > stop_r, "shift below stop")

endmodule
